FILE: src/fixed_step_tick_accumulator_top_assert.svh
// Assertion macros for the fixed step tick accumulator
`ifndef FIXED_STEP_TICK_ACCUMULATOR_TOP_ASSERT_SVH
`define FIXED_STEP_TICK_ACCUMULATOR_TOP_ASSERT_SVH

// clocked assertion, off while reset is held
`define FSTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked assertion, checked during reset too
`define FSTA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fsta_pkg.sv
`default_nettype none
package fsta_pkg;

    localparam int ElapsedW = 32;
    localparam int PeriodW  = 24;
    localparam int CatchupW = 16;
    localparam int TotalW   = 64;
    localparam int QuoW     = 32;
    localparam int CfgW     = 24;
    localparam int CfgIdxW  = 1;
    localparam int OutW     = CatchupW + 2 * TotalW + PeriodW;
    localparam int DivSteps = QuoW;
    localparam int CntW     = $clog2(DivSteps);

    localparam logic [CfgIdxW-1:0] CFG_PERIOD  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_CATCHUP = 1'b1;

    localparam logic [PeriodW-1:0]  PERIOD_RST  = 24'd50000;
    localparam logic [CatchupW-1:0] CATCHUP_RST = 16'd1;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/fsta_ctrl.sv
`default_nettype none
module fsta_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  fsta_pkg::t_sts   i_sts,
    output fsta_pkg::t_cmd   o_cmd
);
    import fsta_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: src/fsta_datapath.sv
`default_nettype none
module fsta_datapath (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire         [fsta_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire         [fsta_pkg::CfgW-1:0]      i_cfg_data,
    input  wire  signed [fsta_pkg::ElapsedW-1:0]  i_delta_us,
    input  fsta_pkg::t_cmd                        i_cmd,
    output fsta_pkg::t_sts                        o_sts,
    output logic        [fsta_pkg::CatchupW-1:0]  o_ticks_to_run,
    output logic        [fsta_pkg::TotalW-1:0]    o_total_ticks,
    output logic        [fsta_pkg::TotalW-1:0]    o_total_dropped,
    output logic        [fsta_pkg::PeriodW-1:0]   o_until_next_us
);
    import fsta_pkg::*;

    logic [PeriodW-1:0]  r_period;
    logic [CatchupW-1:0] r_catchup;
    logic [PeriodW-1:0]  r_rem;
    logic [TotalW-1:0]   r_tot;
    logic [TotalW-1:0]   r_drop;

    logic [PeriodW-1:0]  r_div;
    logic [CatchupW-1:0] r_lim;
    logic [QuoW-1:0]     r_quo;
    logic [PeriodW-1:0]  r_part;
    logic [CntW-1:0]     r_cnt;

    logic [CatchupW-1:0] r_run;
    logic [PeriodW-1:0]  r_until;

    logic                pos;
    logic [QuoW-1:0]     n_acc;
    logic [PeriodW:0]    trial;
    logic [PeriodW:0]    diff;
    logic                ge;
    logic                over;
    logic [QuoW-1:0]     excess;
    logic [CatchupW-1:0] run;

    always_comb begin
        pos    = !i_delta_us[ElapsedW-1] && (i_delta_us != '0);
        n_acc  = {{(QuoW-PeriodW){1'b0}}, r_rem}
               + (pos ? $unsigned(i_delta_us) : {QuoW{1'b0}});
        trial  = {r_part, r_quo[QuoW-1]};
        diff   = trial - {1'b0, r_div};
        ge     = (trial >= {1'b0, r_div});
        over   = (r_quo > {{(QuoW-CatchupW){1'b0}}, r_lim});
        excess = r_quo - {{(QuoW-CatchupW){1'b0}}, r_lim};
        run    = over ? r_lim : r_quo[CatchupW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_catchup <= CATCHUP_RST;
            r_rem     <= '0;
            r_tot     <= '0;
            r_drop    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERIOD:  r_period  <= i_cfg_data;
                    CFG_CATCHUP: r_catchup <= i_cfg_data[CatchupW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_rem <= r_part;
                r_tot <= r_tot + {{(TotalW-CatchupW){1'b0}}, run};
                if (over) begin
                    r_drop <= r_drop + {{(TotalW-QuoW){1'b0}}, excess};
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div  <= (r_period == '0) ? PeriodW'(1) : r_period;
            r_lim  <= (r_catchup == '0) ? CatchupW'(1) : r_catchup;
            r_quo  <= n_acc;
            r_part <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_part <= ge ? diff[PeriodW-1:0] : trial[PeriodW-1:0];
            r_quo  <= {r_quo[QuoW-2:0], ge};
            r_cnt  <= r_cnt + CntW'(1);
        end
        if (i_cmd.finish) begin
            r_run   <= run;
            r_until <= r_div - r_part;
        end
    end

    assign o_sts.div_last   = (r_cnt == CntW'(DivSteps - 1));
    assign o_ticks_to_run   = r_run;
    assign o_total_ticks    = r_tot;
    assign o_total_dropped  = r_drop;
    assign o_until_next_us  = r_until;

endmodule
`default_nettype wire

FILE: src/fixed_step_tick_accumulator_top.sv
// Fixed-timestep tick accumulator. Each input transfer carries the signed
// microseconds elapsed since the last advance; zero or negative values add
// nothing. The sum with the held remainder is divided by the tick period in a
// restoring divider (one quotient bit per cycle). After the divide steps an
// update step writes the result into the output register, and the next input
// is accepted in the cycle after that update. The next input is taken while a
// result still waits in the output register; its update waits until that
// register is free. The period and catch-up limit are captured at the input
// transfer, so write them only while no transfer is in flight. A period or
// catch-up limit of zero acts as one.
`default_nettype none
module fixed_step_tick_accumulator_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [fsta_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  wire  [fsta_pkg::CfgW-1:0]       i_cfg_data,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [fsta_pkg::ElapsedW-1:0]   s_axis_tdata,  // elapsed time in us
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // ticks_to_run, total_ticks, total_dropped, until_next_us
    output logic [fsta_pkg::OutW-1:0]       m_axis_tdata
);
    import fsta_pkg::*;

    t_cmd                cmd;
    t_sts                sts;
    logic [CatchupW-1:0] ticks_to_run;
    logic [TotalW-1:0]   total_ticks;
    logic [TotalW-1:0]   total_dropped;
    logic [PeriodW-1:0]  until_next_us;

    fsta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fsta_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_delta_us      ($signed(s_axis_tdata)),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_ticks_to_run  (ticks_to_run),
        .o_total_ticks   (total_ticks),
        .o_total_dropped (total_dropped),
        .o_until_next_us (until_next_us)
    );

    assign m_axis_tdata = {until_next_us, total_dropped, total_ticks, ticks_to_run};

endmodule
`default_nettype wire

FILE: src/fsta_checker.sv
`default_nettype none
`include "fixed_step_tick_accumulator_top_assert.svh"
module fsta_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [fsta_pkg::OutW-1:0]        m_axis_tdata
);
    import fsta_pkg::*;

    `FSTA_ASSERT_RST(a_rst_out_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `FSTA_ASSERT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
    `FSTA_ASSERT(a_until_nonzero, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[OutW-1:OutW-PeriodW] != '0), "until_next_us is zero")
    `FSTA_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

endmodule

bind fixed_step_tick_accumulator_top fsta_checker u_fsta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
